[hdl/ccdt_pkg.sv]
// Shared types and constants for the coin debounce and credit timer.
// No dependencies; ccdt_cfg_regs, ccdt_core, the top and both sim files use this package.
package ccdt_pkg;

  localparam int unsigned RunW  = 9;
  localparam int unsigned TimeW = 16;
  localparam int unsigned ThrW  = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [RunW-1:0]  RUN_MAX  = '1;
  localparam logic [TimeW-1:0] TIME_MAX = '1;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_TRIGGER_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COIN_SECONDS      = 2'd2;

  // Register reset values.
  localparam logic [ThrW-1:0]  TRIGGER_RESET = 8'd3;
  localparam logic [ThrW-1:0]  RELEASE_RESET = 8'd3;
  localparam logic [TimeW-1:0] COIN_SECONDS_RESET = 16'd600;

  // Item modes.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // The pin idles high.
  localparam logic PIN_IDLE_LEVEL = 1'b1;

  typedef struct packed {
    logic [ThrW-1:0]  trigger_threshold;
    logic [ThrW-1:0]  release_threshold;
    logic [TimeW-1:0] coin_seconds;
  } cfg_t;

  typedef struct packed {
    logic mode;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic             display_select;
    logic [TimeW-1:0] remaining_seconds;
    logic             coin_accepted;
    logic             spurious;
    logic             expired;
    logic             debouncing;
  } result_t;

endpackage

[hdl/ccdt_in_if.sv]
// Input channel of the coin debounce and credit timer: valid, ready, item.
// Depends on nothing.
interface ccdt_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic pin_level;

  modport source (output valid, output mode, output pin_level, input ready);
  modport sink   (input valid, input mode, input pin_level, output ready);
endinterface

[hdl/ccdt_out_if.sv]
// Result channel of the coin debounce and credit timer: valid, ready, result.
// Depends on nothing.
interface ccdt_out_if;
  logic        valid;
  logic        ready;
  logic        display_select;
  logic [15:0] remaining_seconds;
  logic        coin_accepted;
  logic        spurious;
  logic        expired;
  logic        debouncing;

  modport source (output valid, output display_select, output remaining_seconds,
                  output coin_accepted, output spurious, output expired,
                  output debouncing, input ready);
  modport sink   (input valid, input display_select, input remaining_seconds,
                  input coin_accepted, input spurious, input expired,
                  input debouncing, output ready);
endinterface

[hdl/ccdt_cfg_regs.sv]
// Configuration register file of the coin debounce and credit timer.
// Depends on ccdt_pkg.
module ccdt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ccdt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ccdt_pkg::CfgDataW-1:0]  cfg_wdata,
  output ccdt_pkg::cfg_t                 cfg
);

  ccdt_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ccdt_pkg::CFG_TRIGGER_THRESHOLD:
          cfg_nxt.trigger_threshold = cfg_wdata[ccdt_pkg::ThrW-1:0];
        ccdt_pkg::CFG_RELEASE_THRESHOLD:
          cfg_nxt.release_threshold = cfg_wdata[ccdt_pkg::ThrW-1:0];
        ccdt_pkg::CFG_COIN_SECONDS:
          cfg_nxt.coin_seconds = cfg_wdata[ccdt_pkg::TimeW-1:0];
        default: ;  // Unknown indexes are ignored.
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_threshold <= ccdt_pkg::TRIGGER_RESET;
      cfg_r.release_threshold <= ccdt_pkg::RELEASE_RESET;
      cfg_r.coin_seconds      <= ccdt_pkg::COIN_SECONDS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/ccdt_core.sv]
// Debounce and session state of the coin timer with its single-pass update.
// Depends on ccdt_pkg.
module ccdt_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  ccdt_pkg::in_item_t item,
  input  ccdt_pkg::cfg_t     cfg,
  output ccdt_pkg::result_t  res
);

  logic                         window_open_r, window_open_nxt;
  logic                         last_level_r, last_level_nxt;
  logic [ccdt_pkg::RunW-1:0]    low_run_r, low_run_nxt;
  logic [ccdt_pkg::RunW-1:0]    high_run_r, high_run_nxt;
  logic                         armed_r, armed_nxt;
  logic                         session_r, session_nxt;
  logic [ccdt_pkg::TimeW-1:0]   time_left_r, time_left_nxt;

  logic [ccdt_pkg::RunW-1:0]    low_inc, high_inc;
  logic [ccdt_pkg::TimeW:0]     sum;
  logic [ccdt_pkg::TimeW-1:0]   credit_time, tick_time;
  logic                         accepted, spur, exp;

  // Saturating run increments and the credited time.
  assign low_inc  = (low_run_r  < ccdt_pkg::RUN_MAX) ? low_run_r  + 1'b1 : low_run_r;
  assign high_inc = (high_run_r < ccdt_pkg::RUN_MAX) ? high_run_r + 1'b1 : high_run_r;
  assign sum = {1'b0, time_left_r} + {1'b0, cfg.coin_seconds};
  assign credit_time = !session_r ? cfg.coin_seconds :
                       sum[ccdt_pkg::TimeW] ? ccdt_pkg::TIME_MAX :
                       sum[ccdt_pkg::TimeW-1:0];
  assign tick_time = (time_left_r != '0) ? time_left_r - 1'b1 : time_left_r;

  always_comb begin
    window_open_nxt = window_open_r;
    last_level_nxt  = last_level_r;
    low_run_nxt     = low_run_r;
    high_run_nxt    = high_run_r;
    armed_nxt       = armed_r;
    session_nxt     = session_r;
    time_left_nxt   = time_left_r;
    accepted        = 1'b0;
    spur            = 1'b0;
    exp             = 1'b0;
    if (item.mode == ccdt_pkg::MODE_SAMPLE) begin
      last_level_nxt = item.pin_level;
      if (!window_open_r) begin
        // A level change opens the window; the opening sample is not counted.
        if (item.pin_level != last_level_r) begin
          window_open_nxt = 1'b1;
          low_run_nxt     = '0;
          high_run_nxt    = '0;
          armed_nxt       = 1'b0;
        end
      end else if (!item.pin_level) begin
        high_run_nxt = '0;
        low_run_nxt  = low_inc;
        if (low_inc > {1'b0, cfg.trigger_threshold}) begin
          armed_nxt = 1'b1;
        end
      end else begin
        low_run_nxt  = '0;
        high_run_nxt = high_inc;
        if (high_inc > {1'b0, cfg.release_threshold}) begin
          window_open_nxt = 1'b0;
          armed_nxt       = 1'b0;
          high_run_nxt    = '0;
          if (armed_r) begin
            accepted      = 1'b1;
            session_nxt   = 1'b1;
            time_left_nxt = credit_time;
          end else begin
            spur = 1'b1;
          end
        end
      end
    end else if (!window_open_r) begin
      // Ticks count the session down and are ignored inside a window.
      time_left_nxt = tick_time;
      if (tick_time == '0 && session_r) begin
        session_nxt = 1'b0;
        exp         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_open_r <= 1'b0;
      last_level_r  <= ccdt_pkg::PIN_IDLE_LEVEL;
      low_run_r     <= '0;
      high_run_r    <= '0;
      armed_r       <= 1'b0;
      session_r     <= 1'b0;
      time_left_r   <= '0;
    end else if (step) begin
      window_open_r <= window_open_nxt;
      last_level_r  <= last_level_nxt;
      low_run_r     <= low_run_nxt;
      high_run_r    <= high_run_nxt;
      armed_r       <= armed_nxt;
      session_r     <= session_nxt;
      time_left_r   <= time_left_nxt;
    end
  end

  assign res.display_select    = session_nxt;
  assign res.remaining_seconds = time_left_nxt;
  assign res.coin_accepted     = accepted;
  assign res.spurious          = spur;
  assign res.expired           = exp;
  assign res.debouncing        = window_open_nxt;

endmodule

[hdl/coin_debounce_credit_timer_top.sv]
// Coin acceptor front end: pin debounce, coin credit and paid-time countdown.
// Each transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while the receiver keeps ready high.
// Reset: synchronous on rst_n low; clears both stages, the debounce and
// session state, and loads the configuration registers with their defaults.
// Depends on ccdt_pkg, ccdt_in_if, ccdt_out_if, ccdt_cfg_regs and ccdt_core.
module coin_debounce_credit_timer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  ccdt_in_if.sink                       in_if,
  ccdt_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [ccdt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ccdt_pkg::CfgDataW-1:0] cfg_wdata
);

  ccdt_pkg::cfg_t     cfg;
  ccdt_pkg::in_item_t s1_item_r;
  ccdt_pkg::result_t  core_res;
  ccdt_pkg::result_t  out_res_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               in_accept, out_free, step;

  // The result register frees up when it is empty or its transaction
  // completes this cycle. The input stage then hands its item on; the input side
  // accepts only while the input register is empty or hands its item on.
  assign out_free  = !out_valid_r || out_if.ready;
  assign step      = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;
  assign in_accept = in_if.valid && in_if.ready;

  ccdt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The core updates its state exactly when the item in the input register
  // moves into the result register, so the next item sees that state.
  ccdt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.mode      <= in_if.mode;
      s1_item_r.pin_level <= in_if.pin_level;
    end
    if (step) begin
      out_res_r <= core_res;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.display_select    = out_res_r.display_select;
  assign out_if.remaining_seconds = out_res_r.remaining_seconds;
  assign out_if.coin_accepted     = out_res_r.coin_accepted;
  assign out_if.spurious          = out_res_r.spurious;
  assign out_if.expired           = out_res_r.expired;
  assign out_if.debouncing        = out_res_r.debouncing;

endmodule

[sim/ccdt_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for the coin debounce and credit timer: predicts every result from the
// accepted input transactions and compares it with what the block delivers.
// Depends on ccdt_pkg, ccdt_in_if and ccdt_out_if.
module ccdt_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  ccdt_in_if                            in_ch,
  ccdt_out_if                           out_ch,
  input  logic                          cfg_we,
  input  logic [ccdt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ccdt_pkg::CfgDataW-1:0] cfg_wdata,
  output int unsigned                   fail_count,
  output int unsigned                   outstanding
);
  import ccdt_pkg::*;

  // Shadow configuration.
  logic [ThrW-1:0]  trig_thr;
  logic [ThrW-1:0]  rel_thr;
  logic [TimeW-1:0] coin_secs;

  // Shadow debounce and session state.
  logic             win_open;
  logic             prev_level;
  logic [RunW-1:0]  low_run;
  logic [RunW-1:0]  high_run;
  logic             coin_armed;
  logic             paid;
  logic [TimeW-1:0] secs_left;

  result_t     pending_results[$];
  int unsigned n_fail = 0;
  int unsigned n_pending = 0;

  assign fail_count  = n_fail;
  assign outstanding = n_pending;

  // Adds one coin worth of paid time; the sum saturates at the top of the counter.
  function automatic void add_credit();
    logic [TimeW:0] sum;
    sum = {1'b0, secs_left} + {1'b0, coin_secs};
    if (!paid) begin
      secs_left = coin_secs;
      paid = 1'b1;
    end else begin
      secs_left = sum[TimeW] ? TIME_MAX : sum[TimeW-1:0];
    end
  endfunction

  function automatic result_t next_acceptor_result(in_item_t it);
    result_t r;
    r = '0;
    if (it.mode == MODE_SAMPLE) begin
      if (!win_open) begin
        // A level change opens the window; the opening sample is not counted.
        if (it.pin_level != prev_level) begin
          win_open   = 1'b1;
          low_run    = '0;
          high_run   = '0;
          coin_armed = 1'b0;
        end
      end else if (it.pin_level != PIN_IDLE_LEVEL) begin
        high_run = '0;
        if (low_run != RUN_MAX) low_run++;
        if (low_run > {1'b0, trig_thr}) coin_armed = 1'b1;
      end else begin
        low_run = '0;
        if (high_run != RUN_MAX) high_run++;
        if (high_run > {1'b0, rel_thr}) begin
          win_open = 1'b0;
          if (coin_armed) begin
            r.coin_accepted = 1'b1;
            add_credit();
          end else begin
            r.spurious = 1'b1;
          end
          coin_armed = 1'b0;
          low_run    = '0;
          high_run   = '0;
        end
      end
      prev_level = it.pin_level;
    end else if (!win_open) begin
      if (secs_left != '0) secs_left--;
      if (secs_left == '0 && paid) begin
        paid      = 1'b0;
        r.expired = 1'b1;
      end
    end
    r.display_select    = paid;
    r.remaining_seconds = secs_left;
    r.debouncing        = win_open;
    return r;
  endfunction

  function automatic void compare_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    result_t  want;
    in_item_t item;
    if (!rst_n) begin
      trig_thr   = TRIGGER_RESET;
      rel_thr    = RELEASE_RESET;
      coin_secs  = COIN_SECONDS_RESET;
      win_open   = 1'b0;
      prev_level = PIN_IDLE_LEVEL;
      low_run    = '0;
      high_run   = '0;
      coin_armed = 1'b0;
      paid       = 1'b0;
      secs_left  = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIGGER_THRESHOLD: trig_thr  = cfg_wdata[ThrW-1:0];
          CFG_RELEASE_THRESHOLD: rel_thr   = cfg_wdata[ThrW-1:0];
          CFG_COIN_SECONDS:      coin_secs = cfg_wdata[TimeW-1:0];
          default: ;
        endcase
      end
      // Results are checked before this edge's input is predicted; the block registers
      // each input, so a result never belongs to the input accepted at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no expectation waiting");
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          compare_field("display_select", want.display_select, out_ch.display_select);
          compare_field("remaining_seconds", want.remaining_seconds,
                        out_ch.remaining_seconds);
          compare_field("coin_accepted", want.coin_accepted, out_ch.coin_accepted);
          compare_field("spurious", want.spurious, out_ch.spurious);
          compare_field("expired", want.expired, out_ch.expired);
          compare_field("debouncing", want.debouncing, out_ch.debouncing);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        item.mode      = in_ch.mode;
        item.pin_level = in_ch.pin_level;
        pending_results.push_back(next_acceptor_result(item));
      end
    end
    n_pending = pending_results.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Top of the coin debounce and credit timer testbench: clock, reset, stimulus and verdict.
// Depends on ccdt_pkg, the two channel interfaces, the block and ccdt_result_checker.
module testbench;
  import ccdt_pkg::*;

  // Write to this index must be ignored by the block.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_INDEX = 2'd3;
  // Cycles without any transaction before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 4000;
  // Length of the long receiver hold-off that backs the pipeline up.
  localparam int unsigned HOLD_CYCLES = 200;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  ccdt_in_if  in_ch();
  ccdt_out_if out_ch();

  int unsigned fail_count;
  int unsigned outstanding;

  // Shared between the sender and the receiver: random idling on or off, and a
  // one-shot request for the receiver to hold off for a long stretch.
  logic idle_on = 1'b1;
  logic hold_req = 1'b0;

  // Thresholds in force, used to shape coin sequences that actually reach a close.
  logic [ThrW-1:0] cur_trig;
  logic [ThrW-1:0] cur_rel;

  int unsigned n_sent = 0;
  int unsigned quiet_cycles = 0;

  coin_debounce_credit_timer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ccdt_result_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: any transaction on either channel counts as progress. A run that sits
  // quiet for too long has hung or lost results, and that is a failure.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver. Ready changes on the falling edge only. Most of the time it drops at
  // random; on request it holds off for a long stretch counted here, so the block's
  // registers fill and its input ready must go low.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= !(idle_on && $urandom_range(99) < 27);
    end
  end

  // Offers one input transaction and returns at the falling edge after it was taken.
  // Random gaps come first, each waiting for a falling edge, so valid is assigned at most once per
  // edge and a valid that stays high is never dropped and raised in the same step.
  task automatic put_item(logic m, logic p);
    while (idle_on && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.pin_level <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted result has come back. Each item
  // yields exactly one result, so an empty expectation store means the block is idle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Writes all three registers, plus an index the block does not decode. The spare
  // upper byte of the threshold writes is random, since only the low byte counts.
  task automatic load_config(logic [ThrW-1:0] trig, logic [ThrW-1:0] rel,
                             logic [TimeW-1:0] secs);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TRIGGER_THRESHOLD;
    cfg_wdata <= {8'($urandom_range(255)), trig};
    @(negedge clk);
    cfg_index <= CFG_RELEASE_THRESHOLD;
    cfg_wdata <= {8'($urandom_range(255)), rel};
    @(negedge clk);
    cfg_index <= CFG_COIN_SECONDS;
    cfg_wdata <= secs;
    @(negedge clk);
    cfg_index <= CFG_UNUSED_INDEX;
    cfg_wdata <= 16'($urandom);
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_trig = trig;
    cur_rel  = rel;
  endtask

  // A well-formed coin pulse with random content: an opening low, a low run of random
  // length around the trigger threshold (so both real and spurious coins occur), an
  // occasional bounce or ignored tick, and a high run long enough to close the window.
  task automatic coin_attempt();
    int unsigned lows;
    int unsigned highs;
    lows  = $urandom_range(int'(cur_trig) + 3);
    highs = int'(cur_rel) + 1 + $urandom_range(2);
    put_item(MODE_SAMPLE, 1'b0);
    for (int unsigned i = 0; i < lows; i++) begin
      if ($urandom_range(9) == 0) put_item(MODE_TICK, 1'($urandom_range(1)));
      put_item(MODE_SAMPLE, 1'b0);
    end
    // A short high glitch clears the low run without closing the window.
    if (cur_rel != 0 && $urandom_range(4) == 0) begin
      put_item(MODE_SAMPLE, 1'b1);
      put_item(MODE_SAMPLE, 1'b0);
    end
    for (int unsigned i = 0; i < highs; i++) put_item(MODE_SAMPLE, 1'b1);
  endtask

  // One random burst: mostly coin pulses, then runs of idle ticks that drain and
  // expire sessions, and some fully random noise.
  task automatic random_burst();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      coin_attempt();
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 12)) put_item(MODE_TICK, 1'($urandom_range(1)));
    end else begin
      repeat ($urandom_range(1, 4))
        put_item(1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(logic [ThrW-1:0] trig, logic [ThrW-1:0] rel,
                           logic [TimeW-1:0] secs, int unsigned n_items);
    int unsigned stop_at;
    wait_idle();
    load_config(trig, rel, secs);
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) random_burst();
  endtask

  initial begin
    // Every input is known from time zero, while reset is held low.
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_SAMPLE;
    in_ch.pin_level = PIN_IDLE_LEVEL;
    cfg_we          = 1'b0;
    cfg_index       = CFG_TRIGGER_THRESHOLD;
    cfg_wdata       = '0;
    cur_trig        = TRIGGER_RESET;
    cur_rel         = RELEASE_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: a tick with no session, an idle sample at the resting level,
    // a window whose low run stays under the trigger threshold, a tick inside the
    // window that must be ignored, and a high run that closes it as spurious.
    put_item(MODE_TICK, 1'b0);
    put_item(MODE_SAMPLE, 1'b1);
    put_item(MODE_SAMPLE, 1'b0);
    put_item(MODE_SAMPLE, 1'b0);
    put_item(MODE_SAMPLE, 1'b0);
    put_item(MODE_TICK, 1'b1);
    repeat (4) put_item(MODE_SAMPLE, 1'b1);

    // Zero thresholds and zero coin time: one low arms, one high closes, and the
    // credit opens a session with no time that the next tick ends.
    wait_idle();
    load_config(8'd0, 8'd0, 16'd0);
    put_item(MODE_SAMPLE, 1'b0);
    put_item(MODE_SAMPLE, 1'b0);
    put_item(MODE_SAMPLE, 1'b1);
    put_item(MODE_TICK, 1'b0);
    put_item(MODE_TICK, 1'b1);

    // A window closed at once by its first high is spurious; then a coin starts a
    // session and a second coin extends it before a tick counts it down.
    wait_idle();
    load_config(8'd0, 8'd0, 16'd7);
    put_item(MODE_SAMPLE, 1'b0);
    put_item(MODE_SAMPLE, 1'b1);
    repeat (2) begin
      put_item(MODE_SAMPLE, 1'b0);
      put_item(MODE_SAMPLE, 1'b0);
      put_item(MODE_SAMPLE, 1'b1);
    end
    put_item(MODE_TICK, 1'b0);

    // Random phases with short coin times so that sessions expire often.
    run_phase(8'd2, 8'd1, 16'd9, 130);

    // The receiver stalls for a long stretch while the sender keeps offering. The
    // pipeline is drained first so the hold-off starts only once the phase begins.
    wait_idle();
    hold_req = 1'b1;
    run_phase(8'd5, 8'd3, 16'd20, 130);

    // A stretch with no idling on either side, at random thresholds.
    wait_idle();
    idle_on = 1'b0;
    run_phase(8'($urandom_range(6)), 8'($urandom_range(6)),
              16'($urandom_range(1, 30)), 150);
    idle_on = 1'b1;

    run_phase(8'd0, 8'd6, 16'd1, 120);
    run_phase(8'd0, 8'd0, 16'd0, 80);
    run_phase(8'd3, 8'd3, 16'd600, 120);

    // Highest thresholds: a low run long enough to saturate its counter, then the
    // longest high run that can close a window.
    wait_idle();
    load_config(8'd255, 8'd255, 16'd300);
    put_item(MODE_SAMPLE, 1'b0);
    repeat (520) put_item(MODE_SAMPLE, 1'b0);
    repeat (256) put_item(MODE_SAMPLE, 1'b1);
    repeat (3) put_item(MODE_TICK, 1'b0);

    // Full coin time: repeated credits must saturate the remaining time.
    run_phase(8'd1, 8'd1, 16'hFFFF, 100);

    // Drain, let the pipeline show any stray result, then judge.
    wait_idle();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[coin_debounce_credit_timer_top.f]
hdl/ccdt_pkg.sv
hdl/ccdt_in_if.sv
hdl/ccdt_out_if.sv
hdl/ccdt_cfg_regs.sv
hdl/ccdt_core.sv
hdl/coin_debounce_credit_timer_top.sv
sim/ccdt_result_checker.sv
sim/testbench.sv
